// ----- src/slj_pkg.sv -----
// ----------------------------------------------------------------------------
// slj_pkg
// Shared constants for the split Lennard-Jones wall force block.
// ----------------------------------------------------------------------------
package slj_pkg;
    localparam int DIST_FRAC_BITS = 16;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN_MAG = 64'h8000_0000_0000_0000;

    // ceil(2^64 / 3): high half of x times this is floor(x / 3) for x below 2^63
    localparam logic [63:0] DIV3_MAGIC = 64'h5555_5555_5555_5556;

    localparam logic [2:0] CFG_WALL_POS = 3'd0;
    localparam logic [2:0] CFG_SIDE = 3'd1;
    localparam logic [2:0] CFG_CUTOFF = 3'd2;
    localparam logic [2:0] CFG_SWITCH = 3'd3;
    localparam logic [2:0] CFG_REP = 3'd4;
    localparam logic [2:0] CFG_ATT = 3'd5;
    localparam logic [2:0] CFG_EPS = 3'd6;
    localparam logic [2:0] CFG_LAMBDA = 3'd7;

    localparam logic [1:0] ST_NOGRP = 2'd0;
    localparam logic [1:0] ST_CUTOFF = 2'd1;
    localparam logic [1:0] ST_APPLIED = 2'd2;
    localparam logic [1:0] ST_WALL = 2'd3;

    // saturating signed add
    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? SMIN_MAG : SMAX;
        return s;
    endfunction

    function automatic logic [63:0] sneg(input logic [63:0] a);
        return (a == SMIN_MAG) ? SMAX : (64'd0 - a);
    endfunction

    function automatic logic [63:0] smag(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction
endpackage

// ----- src/slj_mul.sv -----
// ----------------------------------------------------------------------------
// slj_mul
// Shared multiplier: (a*b)>>32 of two magnitudes, one 32x32 partial per cycle.
// The high half of the full product is available as well.
// ----------------------------------------------------------------------------
module slj_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_lim,
    output logic        o_done,
    output logic [63:0] o_p,
    output logic [63:0] o_hi
);
    logic [2:0]   r_step;
    logic         r_busy;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_lim;
    logic [127:0] r_acc;
    logic         r_done;
    logic [63:0]  r_p;
    logic [31:0]  w_x;
    logic [31:0]  w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        case (r_step[1:0])
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  w_sh = 128'(w_pp); end
            2'd1: begin w_x = r_a[31:0];  w_y = r_b[63:32]; w_sh = 128'(w_pp) << 32; end
            2'd2: begin w_x = r_a[63:32]; w_y = r_b[31:0];  w_sh = 128'(w_pp) << 32; end
            default: begin w_x = r_a[63:32]; w_y = r_b[63:32]; w_sh = 128'(w_pp) << 64; end
        endcase
    end
    assign w_pp = 64'(w_x) * 64'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_a <= i_a;
                r_b <= i_b;
                r_lim <= i_lim;
                r_acc <= 128'd0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_acc[127:96] != 32'd0 || r_acc[95:32] > r_lim)
                        r_p <= r_lim;
                    else
                        r_p <= r_acc[95:32];
                end else begin
                    r_acc <= r_acc + w_sh;
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_p = r_p;
    assign o_hi = r_acc[127:64];
endmodule

// ----- src/slj_div.sv -----
// ----------------------------------------------------------------------------
// slj_div
// Restoring divider: 2^(32+D) / delta, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slj_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_d,
    output logic        o_done,
    output logic [63:0] o_q
);
    localparam int NB = 33 + slj_pkg::DIST_FRAC_BITS;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_d;
    logic [33:0] w_t;
    logic        w_bit;

    // dividend is a single one at bit 32+D
    assign w_bit = (r_cnt == 7'(NB - 1));
    assign w_t = {r_rem, w_bit} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'(NB - 1);
                r_rem <= 33'd0;
                r_q <= 64'd0;
                r_d <= i_d;
            end else if (r_busy) begin
                if (!w_t[33]) begin
                    r_rem <= w_t[32:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], w_bit};
                    r_q <= {r_q[62:0], 1'b0};
                end
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_q = r_q;
endmodule

// ----- src/split_lj_wall_force.sv -----
// ----------------------------------------------------------------------------
// split_lj_wall_force
// Split 12-6 Lennard-Jones wall force with per-pass energy and force sums.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// input    in         i_valid / o_stall     position, in_group, pass_start
// result   out        o_valid / i_stall     force, virial, totals, status, error
// config   in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// an applied particle: a check state, a restoring divide for 1/delta,
// fifteen multiplies on one shared 32x32 unit (the first two form the energy
// coefficients by a reciprocal of 3) and a state for the sums before the
// result is offered. other particles go from the check state to the result.
// one item at a time; o_stall is high while an item is at work, its result
// waits or a config write is offered. synchronous active-low reset.
module split_lj_wall_force (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_position,
    input  logic        i_in_group,
    input  logic        i_pass_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_force_out,
    output logic [63:0] o_virial_out,
    output logic [63:0] o_energy_total,
    output logic [63:0] o_force_total,
    output logic [1:0]  o_status,
    output logic        o_wall_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_MUL = 3'd2,
                           S_FIN = 3'd3, S_OUT = 3'd4, S_CHK = 3'd5;
    localparam int D = slj_pkg::DIST_FRAC_BITS;

    logic [2:0]  r_state;
    logic [3:0]  r_op;
    logic        r_wait;
    logic [31:0] r_wpos;
    logic        r_side;
    logic [30:0] r_cut, r_sw;
    logic [62:0] r_c1, r_c2, r_eps;
    logic [31:0] r_lam;
    logic [63:0] r_esum, r_fsum;
    logic        r_err;
    logic [32:0] r_delta;
    logic        r_grp;
    logic [63:0] r_rinv, r_r2, r_r6, r_t, r_rep, r_att, r_erep;
    logic [63:0] r_flj, r_elj, r_fw, r_einc, r_vir;
    logic [1:0]  r_status;
    logic [63:0] r_c3, r_c4;

    logic        w_mstart, w_mdone, w_dstart, w_ddone;
    logic [63:0] w_ma, w_mb, w_mlim, w_mp, w_mhi, w_q, w_sres;
    logic [32:0] w_delta;
    logic        w_inner;
    logic [63:0] w_lam, w_eps;

    assign w_lam = {{16{r_lam[31]}}, r_lam, 16'd0};
    assign w_eps = {1'b0, r_eps};
    assign w_inner = r_delta[31:0] < {1'b0, r_sw};
    assign w_delta = r_side ? ({r_wpos[31], r_wpos} - {i_position[31], i_position})
                            : ({i_position[31], i_position} - {r_wpos[31], r_wpos});

    slj_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
                   .i_lim(w_mlim), .o_done(w_mdone), .o_p(w_mp), .o_hi(w_mhi));
    slj_div u_div (.i_clk, .i_rst_n, .i_start(w_dstart), .i_d(r_delta[31:0]),
                   .o_done(w_ddone), .o_q(w_q));

    // operand selection for multiply step r_op (signed ops take magnitudes)
    logic [63:0] w_sa, w_sb;
    logic        w_sneg;
    always_comb begin
        w_sa = 64'd0;
        w_sb = 64'd0;
        case (r_op)
            // c1/12 = (c1/4)/3 and c2/6 = (c2/2)/3 from the high product half
            4'd0: begin w_sa = {3'b0, r_c1[62:2]}; w_sb = slj_pkg::DIV3_MAGIC; end
            4'd1: begin w_sa = {2'b0, r_c2[62:1]}; w_sb = slj_pkg::DIV3_MAGIC; end
            4'd2: begin w_sa = r_rinv; w_sb = r_rinv; end
            4'd3: begin w_sa = r_r2; w_sb = r_r2; end
            4'd4: begin w_sa = r_t; w_sb = r_r2; end
            4'd5: begin w_sa = {1'b0, r_c1}; w_sb = r_r6; end
            4'd6: begin w_sa = r_t; w_sb = r_r6; end
            4'd7: begin w_sa = {1'b0, r_c2}; w_sb = r_r6; end
            4'd8: begin w_sa = r_c3; w_sb = r_r6; end
            4'd9: begin w_sa = r_t; w_sb = r_r6; end
            4'd10: begin w_sa = r_c4; w_sb = r_r6; end
            4'd11: begin w_sa = r_rep - r_att; w_sb = r_rinv; end
            4'd12: begin w_sa = w_lam; w_sb = w_inner ? slj_pkg::sneg(w_eps) : r_elj; end
            4'd13: begin w_sa = w_lam; w_sb = r_flj; end
            default: begin w_sa = r_fw;
                w_sb = {r_delta[31:0], 32'd0} >> D; end
        endcase
    end
    assign w_sneg = w_sa[63] ^ w_sb[63];
    assign w_ma = slj_pkg::smag(w_sa);
    assign w_mb = slj_pkg::smag(w_sb);
    assign w_mlim = w_sneg ? slj_pkg::SMIN_MAG : slj_pkg::SMAX;
    assign w_sres = w_sneg ? (64'd0 - w_mp) : w_mp;

    assign o_stall = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_force_out = r_fw;
    assign o_virial_out = r_vir;
    assign o_energy_total = r_esum;
    assign o_force_total = r_fsum;
    assign o_status = r_status;
    assign o_wall_error = r_err;
    assign w_dstart = (r_state == S_CHK) && r_grp && r_status == slj_pkg::ST_APPLIED;
    assign w_mstart = (r_state == S_MUL) && !r_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= 1'b0;
            r_op <= 4'd0;
            r_wpos <= 32'd0; r_side <= 1'b0; r_cut <= 31'd0; r_sw <= 31'd0;
            r_c1 <= 63'd0; r_c2 <= 63'd0; r_eps <= 63'd0; r_lam <= 32'd65536;
            r_esum <= 64'd0; r_fsum <= 64'd0; r_err <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            slj_pkg::CFG_WALL_POS: r_wpos <= i_cfg_data[31:0];
                            slj_pkg::CFG_SIDE: r_side <= i_cfg_data[0];
                            slj_pkg::CFG_CUTOFF: r_cut <= i_cfg_data[30:0];
                            slj_pkg::CFG_SWITCH: r_sw <= i_cfg_data[30:0];
                            slj_pkg::CFG_REP: r_c1 <= i_cfg_data[62:0];
                            slj_pkg::CFG_ATT: r_c2 <= i_cfg_data[62:0];
                            slj_pkg::CFG_EPS: r_eps <= i_cfg_data[62:0];
                            slj_pkg::CFG_LAMBDA: r_lam <= i_cfg_data[31:0];
                            default: ;
                        endcase
                    end else if (i_valid) begin
                        if (i_pass_start) begin
                            r_esum <= 64'd0; r_fsum <= 64'd0; r_err <= 1'b0;
                        end
                        r_delta <= w_delta;
                        r_grp <= i_in_group;
                        r_fw <= 64'd0; r_vir <= 64'd0;
                        if (!i_in_group) r_status <= slj_pkg::ST_NOGRP;
                        else if ($signed(w_delta) >= $signed({2'b0, r_cut}))
                            r_status <= slj_pkg::ST_CUTOFF;
                        else if ($signed(w_delta) <= 0) r_status <= slj_pkg::ST_WALL;
                        else r_status <= slj_pkg::ST_APPLIED;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_status == slj_pkg::ST_WALL) r_err <= 1'b1;
                    r_state <= (r_status == slj_pkg::ST_APPLIED) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_rinv <= w_q;
                        r_op <= 4'd0;
                        r_wait <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (w_mdone) begin
                        r_wait <= 1'b0;
                        r_op <= r_op + 4'd1;
                        case (r_op)
                            4'd0: r_c3 <= w_mhi;
                            4'd1: r_c4 <= w_mhi;
                            4'd2: r_r2 <= w_mp;
                            4'd3: r_t <= w_mp;
                            4'd4: r_r6 <= w_mp;
                            4'd5: r_t <= w_mp;
                            4'd6: r_rep <= w_mp;
                            4'd7: r_att <= w_mp;
                            4'd8: r_t <= w_mp;
                            4'd9: r_erep <= w_mp;
                            4'd10: r_elj <= r_erep - w_mp;
                            4'd11: r_flj <= r_side ? w_sres : slj_pkg::sneg(w_sres);
                            4'd12: r_einc <= w_inner ? slj_pkg::sadd(
                                       slj_pkg::sadd(r_elj, w_eps), w_sres) : w_sres;
                            4'd13: r_fw <= w_inner ? r_flj : w_sres;
                            default: begin
                                r_vir <= r_side ? w_sres : slj_pkg::sneg(w_sres);
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    r_esum <= slj_pkg::sadd(r_esum, r_einc);
                    r_fsum <= slj_pkg::sadd(r_fsum, r_fw);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
